FILE: sv/hh4d_pkg.sv
// Shared types, codes and constants of the HCI H4 receive deframer.
package hh4d_pkg;

   // Packet type bytes
   localparam logic [7:0] TYPE_EVT = 8'h04;
   localparam logic [7:0] TYPE_ACL = 8'h02;

   // Header lengths minus one, used as last run index
   localparam logic [1:0] EVT_HDR_LAST = 2'd1;
   localparam logic [1:0] ACL_HDR_LAST = 2'd3;

   // Register reset values
   localparam logic [7:0]  MAX_EVT_RESET = 8'd255;
   localparam logic [15:0] MAX_ACL_RESET = 16'd1024;

   // Configuration register indexes
   localparam int          CSR_INDEX_W      = 2;
   localparam logic [1:0]  CSR_MAX_EVENT    = 2'd0;
   localparam logic [1:0]  CSR_MAX_ACL      = 2'd1;

   // Result status codes
   localparam logic [1:0] STATUS_DATA         = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN_TYPE = 2'd1;
   localparam logic [1:0] STATUS_OVERSIZE     = 2'd2;

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Work the front hands to the back
   typedef enum logic [1:0] {
      OP_UNKNOWN_TYPE,
      OP_OVERSIZE,
      OP_HEADER_RUN,
      OP_PAYLOAD
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic             kind;      // 0 event, 1 ACL
      logic             len_zero;  // header run is the whole packet
      logic             last;      // payload byte ends the packet
      logic [7:0]       data;      // payload byte
      logic [3:0][7:0]  hdr;       // header bytes, entry 0 first
   } cmd_type;

endpackage

FILE: sv/hci_h4_receive_deframer.sv
// Top level of the HCI H4 receive deframer.
// Splits a received UART byte stream into HCI H4 event and ACL packets. A
// front end takes one byte per cycle whenever its four-entry command queue
// has room, tracks type, header and payload, and turns each byte into zero
// or one command; a result sequencer behind the queue emits one result beat
// per cycle while the output is not stalled, through a registered output
// stage. A known type byte, a non-final header byte or a discarded payload
// byte makes no result; payload and unknown type bytes make one; the final
// header byte makes one beat for an oversize packet, else two (event) or
// four (ACL) beats. The output sequencer's one beat per cycle sets the
// sustained rate. Configuration writes complete in the cycle they are
// presented and must be made while the block is idle; index 0 is the event
// payload limit, index 1 the ACL payload limit, other indexes are ignored.
module hci_h4_receive_deframer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_data_byte,
   output logic                              rsp_packet_kind,
   output logic                              rsp_packet_start,
   output logic                              rsp_packet_end,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_run_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hh4d_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                       csr_data
);

   hh4d_pkg::cmd_type push_cmd;
   hh4d_pkg::cmd_type head_cmd;
   logic              push;
   logic              full;
   logic              pop;
   logic              head_valid;

   assign csr_ready = 1'b1;

   hh4d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rx_byte    (req_rx_byte),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (full),
      .cmd_push   (push),
      .cmd        (push_cmd)
   );

   hh4d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   hh4d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_packet_kind  (rsp_packet_kind),
      .rsp_packet_start (rsp_packet_start),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_status       (rsp_status),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

FILE: sv/hh4d_front.sv
// Front end: accepts UART bytes, tracks packet framing and issues commands.
module hh4d_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         rx_byte,
   input  logic                               csr_valid,
   input  logic [hh4d_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [15:0]                        csr_data,
   input  logic                               queue_full,
   output logic                               cmd_push,
   output hh4d_pkg::cmd_type                  cmd
);

   typedef enum logic [1:0] {
      PH_TYPE,
      PH_HEADER,
      PH_PAYLOAD,
      PH_DISCARD
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic            kind_ff, kind_in;
   logic [1:0]      hcount_ff, hcount_in;
   logic [15:0]     remain_ff, remain_in;
   logic [3:0][7:0] store_ff, store_in;
   logic [7:0]      max_evt_ff, max_evt_in;
   logic [15:0]     max_acl_ff, max_acl_in;

   logic            accept;
   logic            hdr_last;
   logic [15:0]     pay_len;
   logic [15:0]     max_len;
   logic [3:0][7:0] hdr_next;
   logic [15:0]     remain_dec;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Header bytes including the one arriving now
   always_comb begin
      hdr_next            = store_ff;
      hdr_next[hcount_ff] = rx_byte;
   end

   assign hdr_last   = kind_ff ? (hcount_ff == hh4d_pkg::ACL_HDR_LAST)
                               : (hcount_ff == hh4d_pkg::EVT_HDR_LAST);
   assign pay_len    = kind_ff ? {rx_byte, store_ff[2]} : {8'h00, rx_byte};
   assign max_len    = kind_ff ? max_acl_ff : {8'h00, max_evt_ff};
   assign remain_dec = remain_ff - 16'd1;

   // Configuration writes
   always_comb begin
      max_evt_in = max_evt_ff;
      max_acl_in = max_acl_ff;
      if (csr_valid) begin
         unique case (csr_index)
            hh4d_pkg::CSR_MAX_EVENT: max_evt_in = csr_data[7:0];
            hh4d_pkg::CSR_MAX_ACL:   max_acl_in = csr_data;
            default: ;
         endcase
      end
   end

   // Framing state machine
   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      hcount_in = hcount_ff;
      remain_in = remain_ff;
      store_in  = store_ff;
      cmd_push  = 1'b0;
      cmd.op       = hh4d_pkg::OP_UNKNOWN_TYPE;
      cmd.kind     = kind_ff;
      cmd.len_zero = 1'b0;
      cmd.last     = 1'b0;
      cmd.data     = rx_byte;
      cmd.hdr      = hdr_next;
      if (accept) begin
         unique case (phase_ff)
            PH_TYPE: begin
               if (rx_byte == hh4d_pkg::TYPE_EVT || rx_byte == hh4d_pkg::TYPE_ACL) begin
                  kind_in   = (rx_byte == hh4d_pkg::TYPE_ACL);
                  hcount_in = 2'd0;
                  phase_in  = PH_HEADER;
               end else begin
                  cmd_push = 1'b1;
                  cmd.op   = hh4d_pkg::OP_UNKNOWN_TYPE;
                  cmd.kind = 1'b0;
               end
            end
            PH_HEADER: begin
               store_in  = hdr_next;
               hcount_in = hcount_ff + 2'd1;
               if (hdr_last) begin
                  hcount_in = 2'd0;
                  remain_in = pay_len;
                  cmd_push  = 1'b1;
                  if (pay_len > max_len) begin
                     cmd.op   = hh4d_pkg::OP_OVERSIZE;
                     phase_in = PH_DISCARD;
                  end else begin
                     cmd.op       = hh4d_pkg::OP_HEADER_RUN;
                     cmd.len_zero = (pay_len == 16'd0);
                     phase_in     = (pay_len == 16'd0) ? PH_TYPE : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               remain_in = remain_dec;
               cmd_push  = 1'b1;
               cmd.op    = hh4d_pkg::OP_PAYLOAD;
               cmd.last  = (remain_dec == 16'd0);
               if (remain_dec == 16'd0) phase_in = PH_TYPE;
            end
            PH_DISCARD: begin
               remain_in = remain_dec;
               if (remain_dec == 16'd0) phase_in = PH_TYPE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         kind_ff    <= 1'b0;
         hcount_ff  <= 2'd0;
         remain_ff  <= 16'd0;
         max_evt_ff <= hh4d_pkg::MAX_EVT_RESET;
         max_acl_ff <= hh4d_pkg::MAX_ACL_RESET;
      end else begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         hcount_ff  <= hcount_in;
         remain_ff  <= remain_in;
         max_evt_ff <= max_evt_in;
         max_acl_ff <= max_acl_in;
      end
      // header bytes carry no reset
      store_ff <= store_in;
   end

endmodule

FILE: sv/hh4d_queue.sv
// Short command queue between the front end and the result sequencer.
module hh4d_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hh4d_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output hh4d_pkg::cmd_type  head_cmd
);

   hh4d_pkg::cmd_type                 entry_ff [hh4d_pkg::QUEUE_DEPTH];
   logic [hh4d_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [hh4d_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [hh4d_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == hh4d_pkg::QUEUE_CNT_W'(hh4d_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   // Fill count never exceeds the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hh4d_pkg::QUEUE_CNT_W'(hh4d_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");

   // No pop from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue underflow");

   // No push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue overflow");

   // Count rises by one after a push without a pop
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count mismatch");

endmodule

FILE: sv/hh4d_back.sv
// Result sequencer: expands queued commands into result beats, one per cycle while the output is not stalled.
module hh4d_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  hh4d_pkg::cmd_type  head_cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_data_byte,
   output logic               rsp_packet_kind,
   output logic               rsp_packet_start,
   output logic               rsp_packet_end,
   output logic [1:0]         rsp_status,
   output logic               rsp_run_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       kind_ff, kind_in;
   logic       start_ff, start_in;
   logic       end_ff, end_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;

   logic       slot_free;
   logic       emit;
   logic [1:0] run_last_idx;

   assign slot_free    = !valid_ff || rsp_ready;
   assign emit         = slot_free && head_valid;
   assign run_last_idx = head_cmd.kind ? hh4d_pkg::ACL_HDR_LAST : hh4d_pkg::EVT_HDR_LAST;

   // Build the next result beat from the queue head
   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp_ready;
      data_in   = data_ff;
      kind_in   = kind_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      status_in = status_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (emit) begin
         valid_in  = 1'b1;
         kind_in   = head_cmd.kind;
         start_in  = 1'b0;
         end_in    = 1'b0;
         data_in   = 8'h00;
         last_in   = 1'b1;
         pop       = 1'b1;
         unique case (head_cmd.op)
            hh4d_pkg::OP_UNKNOWN_TYPE: begin
               status_in = hh4d_pkg::STATUS_UNKNOWN_TYPE;
               kind_in   = 1'b0;
            end
            hh4d_pkg::OP_OVERSIZE: begin
               status_in = hh4d_pkg::STATUS_OVERSIZE;
            end
            hh4d_pkg::OP_HEADER_RUN: begin
               status_in = hh4d_pkg::STATUS_DATA;
               data_in   = head_cmd.hdr[idx_ff];
               start_in  = (idx_ff == 2'd0);
               last_in   = (idx_ff == run_last_idx);
               end_in    = last_in && head_cmd.len_zero;
               pop       = last_in;
               idx_in    = last_in ? 2'd0 : idx_ff + 2'd1;
            end
            hh4d_pkg::OP_PAYLOAD: begin
               status_in = hh4d_pkg::STATUS_DATA;
               data_in   = head_cmd.data;
               end_in    = head_cmd.last;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      data_ff   <= data_in;
      kind_ff   <= kind_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_packet_kind  = kind_ff;
   assign rsp_packet_start = start_ff;
   assign rsp_packet_end   = end_ff;
   assign rsp_status       = status_ff;
   assign rsp_run_last     = last_ff;

endmodule
